@@ src/interval_merger_defines.svh @@
// ---------------------------------------------------------------------------
// Interval merger assertion macros
// Shared concurrent assertion helpers for the interval merger.
// ---------------------------------------------------------------------------
`ifndef INTERVAL_MERGER_DEFINES_SVH
`define INTERVAL_MERGER_DEFINES_SVH
`ifndef SYNTHESIS
`define IMR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define IMR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define IMR_ASSERT_IMP(label, clk, rst, ante, cons)
`define IMR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/imr_pkg.sv @@
// ---------------------------------------------------------------------------
// Interval merger package
// Shared constants and command/status types for the interval merger.
// ---------------------------------------------------------------------------
package imr_pkg;

   localparam int MAX_INTERVALS_DEF = 64;
   localparam int COORD_W = 32;

   // Write data select codes for the interval store.
   localparam logic [1:0] WSEL_REQ   = 2'd0;
   localparam logic [1:0] WSEL_RDATA = 2'd1;
   localparam logic [1:0] WSEL_KEY   = 2'd2;

   typedef struct packed {
      logic       we;
      logic [1:0] wsel;
      logic       key_ld;
      logic       cur_ld;
      logic       cur_merge;
      logic       out_ld;
      logic       out_last;
      logic       out_ovf;
   } cmd_type;

   typedef struct packed {
      logic key_less;
      logic gap;
      logic out_free;
   } status_type;

endpackage

@@ src/imr_req_if.sv @@
// ---------------------------------------------------------------------------
// Interval merger request channel
// Valid/ready channel carrying one input interval per word.
// ---------------------------------------------------------------------------
interface imr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] interval_start;
   logic signed [31:0] interval_end;
   logic               last_interval;

   modport source (output valid, output interval_start, output interval_end,
                   output last_interval, input ready);
   modport sink   (input valid, input interval_start, input interval_end,
                   input last_interval, output ready);
endinterface

@@ src/imr_rsp_if.sv @@
// ---------------------------------------------------------------------------
// Interval merger response channel
// Valid/ready channel carrying one merged interval per word.
// ---------------------------------------------------------------------------
interface imr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] merged_start;
   logic signed [31:0] merged_end;
   logic               last_merged;
   logic               overflow;

   modport source (output valid, output merged_start, output merged_end,
                   output last_merged, output overflow, input ready);
   modport sink   (input valid, input merged_start, input merged_end,
                   input last_merged, input overflow, output ready);
endinterface

@@ src/imr_datapath.sv @@
// ---------------------------------------------------------------------------
// Interval merger datapath
// Interval store, sort key, current merged interval and output register.
// ---------------------------------------------------------------------------
module imr_datapath #(
   parameter int MAX_INTERVALS = imr_pkg::MAX_INTERVALS_DEF,
   parameter int AW = $clog2(MAX_INTERVALS)
) (
   input  logic                clock,
   input  logic                reset,
   input  imr_pkg::cmd_type    cmd,
   input  logic [AW-1:0]       waddr,
   input  logic [AW-1:0]       raddr,
   output imr_pkg::status_type status,
   imr_req_if.sink             req,
   imr_rsp_if.source           rsp
);
   import imr_pkg::*;

   logic [2*COORD_W-1:0] mem [MAX_INTERVALS];
   logic [2*COORD_W-1:0] rdata_ff;
   logic [2*COORD_W-1:0] key_ff;
   logic [2*COORD_W-1:0] wdata;
   logic signed [COORD_W-1:0] rd_start, rd_end, key_start, key_end;
   logic signed [COORD_W-1:0] cur_start_ff, cur_end_ff;
   logic signed [COORD_W-1:0] out_start_ff, out_end_ff;
   logic out_last_ff, out_ovf_ff;
   logic out_valid_ff, out_valid_in;

   assign rd_start  = rdata_ff[2*COORD_W-1:COORD_W];
   assign rd_end    = rdata_ff[COORD_W-1:0];
   assign key_start = key_ff[2*COORD_W-1:COORD_W];
   assign key_end   = key_ff[COORD_W-1:0];

   always_comb begin
      case (cmd.wsel)
         WSEL_REQ:   wdata = {req.interval_start, req.interval_end};
         WSEL_RDATA: wdata = rdata_ff;
         WSEL_KEY:   wdata = key_ff;
         default:    wdata = key_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.key_ld) begin
         key_ff <= rdata_ff;
      end
      if (cmd.cur_ld) begin
         cur_start_ff <= rd_start;
         cur_end_ff   <= rd_end;
      end else if (cmd.cur_merge && (rd_end > cur_end_ff)) begin
         cur_end_ff <= rd_end;
      end
      if (cmd.out_ld) begin
         out_start_ff <= cur_start_ff;
         out_end_ff   <= cur_end_ff;
         out_last_ff  <= cmd.out_last;
         out_ovf_ff   <= cmd.out_ovf;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp.ready;
      if (cmd.out_ld) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign status.key_less = (key_start < rd_start) ||
                            ((key_start == rd_start) && (key_end < rd_end));
   assign status.gap      = rd_start > cur_end_ff;
   assign status.out_free = !out_valid_ff || rsp.ready;

   assign rsp.valid        = out_valid_ff;
   assign rsp.merged_start = out_start_ff;
   assign rsp.merged_end   = out_end_ff;
   assign rsp.last_merged  = out_last_ff;
   assign rsp.overflow     = out_ovf_ff;

endmodule

@@ src/imr_controller.sv @@
// ---------------------------------------------------------------------------
// Interval merger controller
// Sequences loading, in-place insertion sort and the merge walk.
// ---------------------------------------------------------------------------
module imr_controller #(
   parameter int MAX_INTERVALS = imr_pkg::MAX_INTERVALS_DEF,
   parameter int AW = $clog2(MAX_INTERVALS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   input  imr_pkg::status_type status,
   output imr_pkg::cmd_type    cmd,
   output logic [AW-1:0]       waddr,
   output logic [AW-1:0]       raddr
);
   import imr_pkg::*;

   localparam int CW = $clog2(MAX_INTERVALS + 1);

   localparam logic [2:0] ST_LOAD   = 3'd0;
   localparam logic [2:0] ST_KEY    = 3'd1;
   localparam logic [2:0] ST_KLAT   = 3'd2;
   localparam logic [2:0] ST_CMP    = 3'd3;
   localparam logic [2:0] ST_PUT    = 3'd4;
   localparam logic [2:0] ST_MFIRST = 3'd5;
   localparam logic [2:0] ST_MSTEP  = 3'd6;
   localparam logic [2:0] ST_FINAL  = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, n_ff, n_in, i_ff, i_in, j_ff, j_in, idx_ff, idx_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] addr_w, addr_r;
   logic          room;

   assign room = cnt_ff < CW'(MAX_INTERVALS);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      idx_in    = idx_ff;
      ovf_in    = ovf_ff;
      cmd       = '0;
      cmd.out_ovf = ovf_ff;
      addr_w    = cnt_ff;
      addr_r    = idx_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (room) begin
                  cmd.we   = 1'b1;
                  cmd.wsel = WSEL_REQ;
                  cnt_in   = cnt_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  n_in     = room ? cnt_ff + CW'(1) : cnt_ff;
                  i_in     = CW'(1);
                  state_in = ST_KEY;
               end
            end
         end
         ST_KEY: begin
            if (i_ff >= n_ff) begin
               addr_r   = '0;
               state_in = ST_MFIRST;
            end else begin
               addr_r   = i_ff;
               j_in     = i_ff;
               state_in = ST_KLAT;
            end
         end
         ST_KLAT: begin
            cmd.key_ld = 1'b1;
            addr_r     = j_ff - CW'(1);
            state_in   = ST_CMP;
         end
         ST_CMP: begin
            cmd.we = 1'b1;
            addr_w = j_ff;
            if (status.key_less) begin
               cmd.wsel = WSEL_RDATA;
               j_in     = j_ff - CW'(1);
               if (j_ff == CW'(1)) begin
                  state_in = ST_PUT;
               end else begin
                  addr_r = j_ff - CW'(2);
               end
            end else begin
               cmd.wsel = WSEL_KEY;
               i_in     = i_ff + CW'(1);
               state_in = ST_KEY;
            end
         end
         ST_PUT: begin
            cmd.we   = 1'b1;
            cmd.wsel = WSEL_KEY;
            addr_w   = '0;
            i_in     = i_ff + CW'(1);
            state_in = ST_KEY;
         end
         ST_MFIRST: begin
            cmd.cur_ld = 1'b1;
            if (n_ff == CW'(1)) begin
               state_in = ST_FINAL;
            end else begin
               addr_r   = CW'(1);
               idx_in   = CW'(1);
               state_in = ST_MSTEP;
            end
         end
         ST_MSTEP: begin
            if (!status.gap || status.out_free) begin
               if (status.gap) begin
                  cmd.out_ld = 1'b1;
                  cmd.cur_ld = 1'b1;
               end else begin
                  cmd.cur_merge = 1'b1;
               end
               if (idx_ff == n_ff - CW'(1)) begin
                  state_in = ST_FINAL;
               end else begin
                  idx_in = idx_ff + CW'(1);
                  addr_r = idx_ff + CW'(1);
               end
            end
         end
         ST_FINAL: begin
            if (status.out_free) begin
               cmd.out_ld   = 1'b1;
               cmd.out_last = 1'b1;
               cnt_in       = '0;
               ovf_in       = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign waddr = addr_w[AW-1:0];
   assign raddr = addr_r[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      idx_ff <= idx_in;
   end

endmodule

@@ src/interval_merger.sv @@
// Merges a set of closed signed intervals. Intervals are loaded one per word
// at one word per cycle until the word flagged last_interval arrives; words
// beyond MAX_INTERVALS are dropped and set the overflow flag of the run.
// The store is then sorted in place by start, ties by end, with an insertion
// sort over a memory with one read and one write port: each entry after the
// first is taken as the key and compared with the entries before it, each
// larger entry moving up one place, until the key is written into its slot.
// A merge walk follows, emitting merged intervals in ascending order as it
// goes, the final one flagged last_merged; it pauses while a merged word is
// ready but the output word is not taken. No new interval is accepted from
// the last word of a run until the final merged word has been loaded into
// the output register.
// ---------------------------------------------------------------------------
// Interval merger top level
// Controller and datapath joined by command and status signals.
// ---------------------------------------------------------------------------
`include "interval_merger_defines.svh"

module interval_merger #(
   parameter int MAX_INTERVALS = imr_pkg::MAX_INTERVALS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   imr_req_if.sink   req_chan,
   imr_rsp_if.source rsp_chan
);
   import imr_pkg::*;

   localparam int AW = $clog2(MAX_INTERVALS);

   cmd_type       cmd;
   status_type    status;
   logic [AW-1:0] waddr;
   logic [AW-1:0] raddr;

   // The controller owns all counters and the run state.
   imr_controller #(
      .MAX_INTERVALS(MAX_INTERVALS),
      .AW           (AW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_last (req_chan.last_interval),
      .req_ready(req_chan.ready),
      .status   (status),
      .cmd      (cmd),
      .waddr    (waddr),
      .raddr    (raddr)
   );

   // The datapath holds the store, the merge registers and the output word.
   imr_datapath #(
      .MAX_INTERVALS(MAX_INTERVALS),
      .AW           (AW)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .waddr (waddr),
      .raddr (raddr),
      .status(status),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   // The output register is only loaded when it is free.
   `IMR_ASSERT_IMP(a_out_ld_free, clock, reset, cmd.out_ld, status.out_free)
   // A waiting response word stays valid until it is taken.
   `IMR_ASSERT_NXT(a_rsp_hold, clock, reset,
      rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid)
   // A non-final word keeps the block loading.
   `IMR_ASSERT_NXT(a_keep_loading, clock, reset,
      req_chan.valid && req_chan.ready && !req_chan.last_interval, req_chan.ready)

endmodule

@@ tb/imr_tb_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Interval merger testbench channels
// The testbench instantiates the interfaces of the block from src; this file
// only carries the small record type used for stimulus tables.
// ---------------------------------------------------------------------------
package imr_tb_pkg;

   typedef struct {
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic               last;
   } span_word_type;

endpackage

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Interval merger testbench
// Loads sets of signed intervals, predicts the sorted and merged output with
// a behavioral merger, and compares every response word field by field.
// ---------------------------------------------------------------------------
module testbench;
   import imr_tb_pkg::*;

   localparam int CAP = 64;

   logic clock;
   logic reset;
   int   fails;

   imr_req_if req_chan ();
   imr_rsp_if rsp_chan ();

   interval_merger #(.MAX_INTERVALS(CAP)) DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   // Expected merged words, oldest first.
   typedef struct {
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic               last;
      logic               ovf;
   } merged_word_type;

   merged_word_type pending_merges[$];

   // Predictor state: the intervals loaded so far in the current set.
   span_word_type loaded_spans[$];
   bit            set_overflowed;

   function automatic bit span_before(span_word_type a, span_word_type b);
      if (a.lo != b.lo) return a.lo < b.lo;
      return a.hi < b.hi;
   endfunction

   // Record one accepted interval; when it closes the set, sort and merge.
   task automatic absorb_interval(span_word_type w);
      span_word_type   key;
      merged_word_type m;
      int              j;
      logic signed [31:0] cur_lo, cur_hi;
      if (loaded_spans.size() < CAP) loaded_spans.insert(loaded_spans.size(), w);
      else set_overflowed = 1;
      if (!w.last) return;
      for (int i = 1; i < loaded_spans.size(); i++) begin
         key = loaded_spans[i];
         j = i;
         while (j > 0 && span_before(key, loaded_spans[j-1])) begin
            loaded_spans[j] = loaded_spans[j-1];
            j--;
         end
         loaded_spans[j] = key;
      end
      cur_lo = loaded_spans[0].lo;
      cur_hi = loaded_spans[0].hi;
      for (int i = 1; i < loaded_spans.size(); i++) begin
         if (loaded_spans[i].lo > cur_hi) begin
            m.lo = cur_lo; m.hi = cur_hi; m.last = 0; m.ovf = set_overflowed;
            pending_merges.insert(pending_merges.size(), m);
            cur_lo = loaded_spans[i].lo;
            cur_hi = loaded_spans[i].hi;
         end else if (loaded_spans[i].hi > cur_hi) begin
            cur_hi = loaded_spans[i].hi;
         end
      end
      m.lo = cur_lo; m.hi = cur_hi; m.last = 1; m.ovf = set_overflowed;
      pending_merges.insert(pending_merges.size(), m);
      loaded_spans.delete();
      set_overflowed = 0;
   endtask

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Watchdog: worst case is full sorts of 64 entries plus output stalls.
   initial begin
      #60_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Directed table. Where the merged result is obvious, it is typed in and
   // the first response words are checked against it as well.
   span_word_type   directed[$];
   merged_word_type typed_results[$];
   int              rsp_seen = 0;

   task automatic put_span(int lo, int hi, bit last);
      span_word_type w;
      w.lo = lo; w.hi = hi; w.last = last;
      directed.insert(directed.size(), w);
   endtask

   task automatic put_typed(int lo, int hi, bit last, bit ovf);
      merged_word_type m;
      m.lo = lo; m.hi = hi; m.last = last; m.ovf = ovf;
      typed_results.insert(typed_results.size(), m);
   endtask

   // Random set: mostly small sets, occasionally a near-full, full or overfull one
   // while enough of the word budget is left.
   task automatic random_set(input int room_left, output span_word_type set[$]);
      span_word_type w;
      int n, mode, base;
      set.delete();
      mode = $urandom_range(0, 19);
      n = (mode == 0 && room_left >= 66) ? $urandom_range(60, 66) : $urandom_range(1, 8);
      base = $urandom;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: begin
               w.lo = $urandom;
               w.hi = $urandom;
            end
            1: begin
               w.lo = $urandom;
               w.hi = w.lo;
            end
            default: begin
               w.lo = base + $signed($urandom_range(0, 40)) - 20;
               w.hi = w.lo + $urandom_range(0, 10);
               if (w.hi < w.lo) w.hi = w.lo;
            end
         endcase
         w.last = (i == n - 1);
         set.insert(set.size(), w);
      end
   endtask

   // Sender: bursts of words separated by random gaps.
   task automatic send_word(span_word_type w);
      req_chan.valid          <= 1;
      req_chan.interval_start <= w.lo;
      req_chan.interval_end   <= w.hi;
      req_chan.last_interval  <= w.last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      absorb_interval(w);
      @(negedge clock);
   endtask

   int burst_left;

   task automatic send_paced(span_word_type w);
      if (burst_left == 0) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      send_word(w);
      burst_left--;
   endtask

   initial begin
      span_word_type set[$];
      int sent;
      int drain_cycles;
      fails = 0;
      burst_left = 0;
      req_chan.valid = 0;
      req_chan.interval_start = 0;
      req_chan.interval_end = 0;
      req_chan.last_interval = 0;
      reset = 1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Single point interval at the negative extreme.
      put_span(32'sh8000_0000, 32'sh8000_0000, 1);
      put_typed(32'sh8000_0000, 32'sh8000_0000, 1, 0);
      // Full range interval.
      put_span(32'sh8000_0000, 32'sh7fff_ffff, 1);
      put_typed(32'sh8000_0000, 32'sh7fff_ffff, 1, 0);
      // Touching intervals merge; out of order input gets sorted.
      put_span(5, 9, 0);
      put_span(0, 5, 1);
      put_typed(0, 9, 1, 0);
      // Disjoint intervals straddling zero, with a signed ordering check.
      put_span(32'sh7fff_fff0, 32'sh7fff_ffff, 0);
      put_span(-10, -1, 0);
      put_span(1, 2, 1);
      // Equal starts break ties by end; a contained interval is absorbed.
      put_span(3, 4, 0);
      put_span(3, 20, 0);
      put_span(6, 8, 0);
      put_span(21, 22, 1);
      // Start above end passes through unchecked.
      put_span(10, 2, 0);
      put_span(-5, -6, 1);
      // Alternating bit patterns.
      put_span(32'sh5555_5555, 32'sh5555_5555, 0);
      put_span(32'shaaaa_aaaa, 32'shaaaa_aaaa, 1);

      foreach (directed[i]) send_paced(directed[i]);
      sent = directed.size();

      // Random sets, with an overfull set right after the directed part
      // so overflow with a dropped flagged word is always covered.
      for (int i = 0; i < 66; i++) begin
         span_word_type w;
         w.lo = $urandom; w.hi = w.lo; w.last = (i == 65);
         send_paced(w);
      end
      sent += 66;
      while (sent < 170) begin
         random_set(170 - sent, set);
         foreach (set[i]) send_paced(set[i]);
         sent += set.size();
      end
      req_chan.valid <= 0;

      drain_cycles = 0;
      while (pending_merges.size() != 0 && drain_cycles < 200000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (200) @(posedge clock);
      if (fails == 0 && pending_merges.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Receiver: ready follows its own pattern of stalls, with quiet stretches.
   int stall_phase;
   initial begin
      rsp_chan.ready = 0;
      stall_phase = 0;
      forever begin
         @(negedge clock);
         stall_phase = (stall_phase + 1) % 97;
         if (stall_phase < 30) rsp_chan.ready <= 1;
         else rsp_chan.ready <= ($urandom_range(0, 2) != 0);
      end
   end

   // Checker: every accepted merged word is matched to the oldest prediction,
   // and the first words also to the typed rows of the directed table.
   always @(posedge clock) begin
      merged_word_type exp_w;
      merged_word_type typ_w;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (rsp_seen < typed_results.size()) begin
            typ_w = typed_results[rsp_seen];
            if (rsp_chan.merged_start !== typ_w.lo || rsp_chan.merged_end !== typ_w.hi ||
                rsp_chan.last_merged !== typ_w.last || rsp_chan.overflow !== typ_w.ovf) begin
               $display("%0t typed row %0d: expected %0d..%0d last=%0b ovf=%0b, got %0d..%0d last=%0b ovf=%0b",
                        $time, rsp_seen, typ_w.lo, typ_w.hi, typ_w.last, typ_w.ovf,
                        rsp_chan.merged_start, rsp_chan.merged_end,
                        rsp_chan.last_merged, rsp_chan.overflow);
               fails++;
            end
         end
         rsp_seen++;
         if (pending_merges.size() == 0) begin
            $display("%0t unexpected word: expected none, got %0d..%0d last=%0b ovf=%0b",
                     $time, rsp_chan.merged_start, rsp_chan.merged_end,
                     rsp_chan.last_merged, rsp_chan.overflow);
            fails++;
         end else begin
            exp_w = pending_merges.pop_front();
            if (rsp_chan.merged_start !== exp_w.lo) begin
               $display("%0t merged_start: expected %0d, got %0d", $time, exp_w.lo,
                        rsp_chan.merged_start);
               fails++;
            end
            if (rsp_chan.merged_end !== exp_w.hi) begin
               $display("%0t merged_end: expected %0d, got %0d", $time, exp_w.hi,
                        rsp_chan.merged_end);
               fails++;
            end
            if (rsp_chan.last_merged !== exp_w.last) begin
               $display("%0t last_merged: expected %0b, got %0b", $time, exp_w.last,
                        rsp_chan.last_merged);
               fails++;
            end
            if (rsp_chan.overflow !== exp_w.ovf) begin
               $display("%0t overflow: expected %0b, got %0b", $time, exp_w.ovf,
                        rsp_chan.overflow);
               fails++;
            end
         end
      end
   end

endmodule

@@ interval_merger.f @@
+incdir+src
src/imr_pkg.sv
src/imr_req_if.sv
src/imr_rsp_if.sv
src/imr_datapath.sv
src/imr_controller.sv
src/interval_merger.sv
tb/imr_tb_if.sv
tb/testbench.sv
